// ===== design/lru_cache_delayed_promotion_defines.svh =====
// assertion macros shared by the cache block
`ifndef LRU_CACHE_DELAYED_PROMOTION_DEFINES_SVH
`define LRU_CACHE_DELAYED_PROMOTION_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LCDP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcdp check failed");

// next-cycle implication, disabled during reset
`define LCDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcdp check failed");

`endif

// ===== design/lcdp_pkg.sv =====
// types, codes and sizes shared by the cache block
`default_nettype none
package lcdp_pkg;
  localparam int ENTRIES   = 32;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int KEY_W     = 64;
  localparam int SIZE_W    = 24;
  localparam int STAMP_W   = 64;
  localparam int DATA_W    = 32;
  localparam int META_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int NEED_W    = SIZE_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_METADATA = 2'd2;

  localparam logic ACT_GET    = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_FINAL  = 1'b1;

  localparam logic [2:0] CELL_HOLD  = 3'd0;
  localparam logic [2:0] CELL_PREV  = 3'd1;
  localparam logic [2:0] CELL_NEXT  = 3'd2;
  localparam logic [2:0] CELL_LOAD  = 3'd3;
  localparam logic [2:0] CELL_CLEAR = 3'd4;

  typedef struct packed {
    logic              action;
    logic [KEY_W-1:0]  object_key;
    logic [SIZE_W-1:0] object_size;
  } req_t;

  typedef struct packed {
    logic             result_kind;
    logic             found;
    logic [KEY_W-1:0] evicted_key;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [SIZE_W-1:0]  bytes;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [2:0] op;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== design/lcdp_cell.sv =====
// one recency slot of the cache chain: holds an entry and compares its key
`default_nettype none
module lcdp_cell import lcdp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_ctl_t        ctl,
  input  wire entry_t           prev_entry,
  input  wire entry_t           next_entry,
  input  wire entry_t           load_entry,
  input  wire logic [KEY_W-1:0] lookup_key,
  output entry_t                entry,
  output logic                  match
);
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      case (ctl.op)
        CELL_PREV:  entry <= prev_entry;
        CELL_NEXT:  entry <= next_entry;
        CELL_LOAD:  entry <= load_entry;
        CELL_CLEAR: entry.valid <= 1'b0;
        default:    entry <= entry;
      endcase
    end
  end

  assign match = entry.valid && (entry.key == lookup_key);
endmodule
`default_nettype wire

// ===== design/lru_cache_delayed_promotion.sv =====
// top level: recency-ordered cell chain with request sequencer and byte accounting
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    in_data  (req_t)
//   out      out  out_valid / out_ready  out_data (rsp_t)
//   cfg      in   cfg_we                 cfg_index, cfg_data
//
// one request at a time: accept, key lookup, action, final answer;
// a get miss that inserts passes an evict step first, with one eviction notice per evicted entry.
// cell position is recency rank; the chain shifts one step per cycle.
// reset empties the chain at once; a stalled output holds the sequencer.
`default_nettype none
`include "lru_cache_delayed_promotion_defines.svh"
module lru_cache_delayed_promotion import lcdp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire req_t                 in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rsp_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_ACT   = 3'd2;
  localparam logic [2:0] ST_EVICT = 3'd3;
  localparam logic [2:0] ST_FINAL = 3'd4;

  logic [2:0]         state;
  req_t               req;
  logic               hit_any;
  logic [IDX_W-1:0]   hit_idx;
  entry_t             hit_ent;
  logic               fin_found;
  logic [DATA_W-1:0]  promo_delay;
  logic [DATA_W-1:0]  capacity_bytes;
  logic [META_W-1:0]  metadata_bytes;
  logic [STAMP_W-1:0] insert_counter;
  logic [DATA_W-1:0]  bytes_used;

  entry_t             cells   [ENTRIES];
  cell_ctl_t          ctl     [ENTRIES];
  entry_t             prev_in [ENTRIES];
  entry_t             next_in [ENTRIES];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] tail_vec;
  entry_t             load_ent;

  logic [IDX_W-1:0]   enc_idx;
  entry_t             mux_ent;
  logic [KEY_W-1:0]   tail_key;
  logic [SIZE_W-1:0]  tail_bytes;
  logic [NEED_W-1:0]  need;
  logic               oversize;
  logic               over_cap;
  logic               evict_need;
  logic [DATA_W-1:0]  delay_eff;
  logic [STAMP_W-1:0] age;
  logic               promote;
  logic               out_free;
  logic               out_load;
  logic               do_remove;
  logic               do_promote;
  logic               do_evict;
  logic               do_insert;

  function automatic logic [DATA_W-1:0] sub_sat(input logic [DATA_W-1:0] used,
                                                input logic [SIZE_W-1:0] sz,
                                                input logic [META_W-1:0] meta);
    logic [NEED_W-1:0] charge;
    charge = {1'b0, sz} + NEED_W'(meta);
    if (DATA_W'(charge) >= used) sub_sat = '0;
    else sub_sat = used - DATA_W'(charge);
  endfunction

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      lcdp_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl[g]),
        .prev_entry (prev_in[g]),
        .next_entry (next_in[g]),
        .load_entry (load_ent),
        .lookup_key (req.object_key),
        .entry      (cells[g]),
        .match      (match_vec[g])
      );
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_vec[i] = cells[i].valid;
      prev_in[i]   = (i == 0) ? entry_t'('0) : cells[(i == 0) ? 0 : i - 1];
      next_in[i]   = (i == ENTRIES - 1) ? entry_t'('0)
                                        : cells[(i == ENTRIES - 1) ? i : i + 1];
    end
  end

  // lookup muxes: one-hot selects, independent per cell
  always_comb begin
    enc_idx    = '0;
    mux_ent    = '0;
    tail_key   = '0;
    tail_bytes = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      tail_vec[i] = valid_vec[i] && ((i == ENTRIES - 1) ||
                    !valid_vec[(i == ENTRIES - 1) ? i : i + 1]);
      if (match_vec[i]) begin
        enc_idx = enc_idx | IDX_W'(i);
        mux_ent = mux_ent | cells[i];
      end
      if (tail_vec[i]) begin
        tail_key   = tail_key | cells[i].key;
        tail_bytes = tail_bytes | cells[i].bytes;
      end
    end
  end

  always_comb begin
    need       = {1'b0, req.object_size} + NEED_W'(metadata_bytes);
    oversize   = DATA_W'(need) > capacity_bytes;
    over_cap   = ({1'b0, bytes_used} + (DATA_W + 1)'(need)) > {1'b0, capacity_bytes};
    evict_need = valid_vec[0] && (over_cap || valid_vec[ENTRIES-1]);
    delay_eff  = (promo_delay == '0) ? DATA_W'(1) : promo_delay;
    age        = insert_counter - hit_ent.stamp;
    promote    = age > STAMP_W'(delay_eff);
    out_free   = !out_valid || out_ready;
    do_remove  = (state == ST_ACT) && (req.action == ACT_REMOVE) && hit_any;
    do_promote = (state == ST_ACT) && (req.action == ACT_GET) && hit_any && promote;
    do_evict   = (state == ST_EVICT) && evict_need && out_free;
    do_insert  = (state == ST_EVICT) && !evict_need;
    out_load   = do_evict || ((state == ST_FINAL) && out_free);
  end

  // per-cell shift control
  always_comb begin
    load_ent = hit_ent;
    if (do_promote) begin
      load_ent.stamp = insert_counter;
    end else if (do_insert) begin
      load_ent.valid = 1'b1;
      load_ent.key   = req.object_key;
      load_ent.bytes = req.object_size;
      load_ent.stamp = insert_counter + STAMP_W'(1);
    end
    for (int i = 0; i < ENTRIES; i++) begin
      ctl[i].op = CELL_HOLD;
      if (do_remove && (IDX_W'(i) >= hit_idx)) begin
        ctl[i].op = CELL_NEXT;
      end else if (do_promote && (IDX_W'(i) <= hit_idx)) begin
        ctl[i].op = (i == 0) ? CELL_LOAD : CELL_PREV;
      end else if (do_evict && tail_vec[i]) begin
        ctl[i].op = CELL_CLEAR;
      end else if (do_insert) begin
        ctl[i].op = (i == 0) ? CELL_LOAD : CELL_PREV;
      end
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      promo_delay    <= DATA_W'(1);
      capacity_bytes <= DATA_W'(65536);
      metadata_bytes <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY:    promo_delay    <= cfg_data;
        REG_CAPACITY: capacity_bytes <= cfg_data;
        REG_METADATA: metadata_bytes <= cfg_data[META_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      insert_counter <= '0;
      bytes_used     <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          hit_any <= |match_vec;
          hit_idx <= enc_idx;
          hit_ent <= mux_ent;
          state   <= ST_ACT;
        end
        ST_ACT: begin
          if (req.action == ACT_REMOVE) begin
            if (hit_any) bytes_used <= sub_sat(bytes_used, hit_ent.bytes, metadata_bytes);
            fin_found <= hit_any;
            state     <= ST_FINAL;
          end else if (hit_any || oversize) begin
            fin_found <= hit_any;
            state     <= ST_FINAL;
          end else begin
            state <= ST_EVICT;
          end
        end
        ST_EVICT: begin
          if (evict_need) begin
            if (out_free) begin
              out_data.result_kind <= KIND_NOTICE;
              out_data.found       <= 1'b0;
              out_data.evicted_key <= tail_key;
              out_data.last        <= 1'b0;
              bytes_used <= sub_sat(bytes_used, tail_bytes, metadata_bytes);
            end
          end else begin
            // saturating charge of the new object
            logic [DATA_W:0] sum;
            sum = {1'b0, bytes_used} + (DATA_W + 1)'(need);
            bytes_used     <= sum[DATA_W] ? '1 : sum[DATA_W-1:0];
            insert_counter <= insert_counter + STAMP_W'(1);
            fin_found      <= 1'b0;
            state          <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            out_data.result_kind <= KIND_FINAL;
            out_data.found       <= fin_found;
            out_data.evicted_key <= '0;
            out_data.last        <= 1'b1;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // valid entries always fill the head of the chain without gaps
  `LCDP_ASSERT_IMPL(a_chain_packed, clk, rst, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0)
  // keys are unique, so a lookup hits at most one cell
  `LCDP_ASSERT_IMPL(a_hit_unique, clk, rst, state == ST_LOOK, $onehot0(match_vec))
  // an accepted request goes straight to lookup
  `LCDP_ASSERT_NEXT(a_accept_look, clk, rst, in_valid && in_ready, state == ST_LOOK)
endmodule
`default_nettype wire

// ===== tb/sv/tb_lru_cache_delayed_promotion.sv =====
// self-checking testbench for the delayed-promotion lru byte cache
`default_nettype none
module tb_lru_cache_delayed_promotion;
  import lcdp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cache predictor and queue of pending responses
  class cache_scoreboard;
    logic [KEY_W-1:0]   key [ENTRIES];
    logic [SIZE_W-1:0]  bytes [ENTRIES];
    logic [STAMP_W-1:0] stamp [ENTRIES];
    bit                 valid [ENTRIES];
    int                 rank [ENTRIES];
    logic [63:0]        insert_cnt;
    logic [31:0]        used;
    logic [31:0]        delay_reg;
    logic [31:0]        cap_reg;
    logic [4:0]         meta_reg;
    rsp_t               pending_rsp[$];
    int                 mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] = 0;
        rank[i] = 0;
        stamp[i] = '0;
        key[i] = '0;
        bytes[i] = '0;
      end
      insert_cnt = '0;
      used = '0;
      delay_reg = 32'd1;
      cap_reg = 32'd65536;
      meta_reg = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_DELAY:    delay_reg = val;
        REG_CAPACITY: cap_reg = val;
        REG_METADATA: meta_reg = val[META_W-1:0];
        default: ;
      endcase
    endfunction

    function void push(logic kind, logic fnd, logic [KEY_W-1:0] k, logic lst);
      rsp_t r;
      r.result_kind = kind;
      r.found = fnd;
      r.evicted_key = k;
      r.last = lst;
      pending_rsp.push_back(r);
    endfunction

    function void drop(int s);
      logic [63:0] charge;
      charge = 64'(bytes[s]) + 64'(meta_reg);
      for (int i = 0; i < ENTRIES; i++)
        if (valid[i] && rank[i] > rank[s]) rank[i]--;
      valid[s] = 0;
      stamp[s] = '0;
      used = (charge >= 64'(used)) ? 32'd0 : used - charge[31:0];
    endfunction

    function void note_request(req_t rq);
      int hit, n, tail, s;
      logic [63:0] need, dly, sum;
      hit = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (hit < 0 && valid[i] && key[i] == rq.object_key) hit = i;
      if (rq.action == ACT_REMOVE) begin
        if (hit >= 0) drop(hit);
        push(KIND_FINAL, hit >= 0, '0, 1'b1);
        return;
      end
      if (hit >= 0) begin
        dly = (delay_reg == 0) ? 64'd1 : 64'(delay_reg);
        if (insert_cnt - stamp[hit] > dly) begin
          for (int i = 0; i < ENTRIES; i++)
            if (valid[i] && rank[i] < rank[hit]) rank[i]++;
          rank[hit] = 0;
          stamp[hit] = insert_cnt;
        end
        push(KIND_FINAL, 1'b1, '0, 1'b1);
        return;
      end
      need = 64'(rq.object_size) + 64'(meta_reg);
      if (need > 64'(cap_reg)) begin
        push(KIND_FINAL, 1'b0, '0, 1'b1);
        return;
      end
      n = 0;
      for (int i = 0; i < ENTRIES; i++) if (valid[i]) n++;
      while (n > 0 && (64'(used) + need > 64'(cap_reg) || n >= ENTRIES)) begin
        tail = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (tail < 0 && valid[i] && rank[i] == n - 1) tail = i;
        if (tail < 0) break;
        push(KIND_NOTICE, 1'b0, key[tail], 1'b0);
        drop(tail);
        n--;
      end
      s = -1;
      for (int i = 0; i < ENTRIES; i++) if (s < 0 && !valid[i]) s = i;
      if (s >= 0) begin
        for (int j = 0; j < ENTRIES; j++) if (valid[j]) rank[j]++;
        insert_cnt++;
        valid[s] = 1;
        key[s] = rq.object_key;
        bytes[s] = rq.object_size;
        stamp[s] = insert_cnt;
        rank[s] = 0;
        sum = 64'(used) + need;
        used = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      end
      push(KIND_FINAL, 1'b0, '0, 1'b1);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
        return;
      end
      want = pending_rsp.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response mismatch: kind %b/%b found %b/%b key %h/%h last %b/%b",
                   want.result_kind, got.result_kind, want.found, got.found,
                   want.evicted_key, got.evicted_key, want.last, got.last);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  rsp_t out_data;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  cache_scoreboard sb = new();
  int send_idle_pct = 15;
  int recv_idle_pct = 75;
  int unsigned cycles = 0;
  logic [KEY_W-1:0] key_pool [16];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  lru_cache_delayed_promotion u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // response sampling at the rising edge, ready changes on the falling edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) sb.check_response(out_data);
    if (cycles > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send_request(logic act, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] sz);
    req_t rq;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    rq.action = act;
    rq.object_key = k;
    rq.object_size = sz;
    in_data <= rq;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(rq);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_rsp.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic random_phase(int count);
    logic [SIZE_W-1:0] sz;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 3)
        sz = SIZE_W'({$urandom, $urandom} >> $urandom_range(40));
      else
        sz = $urandom_range(1, 3000);
      if (sz == 0) sz = 1;
      if ($urandom_range(99) < 8)
        send_request(ACT_GET, {$urandom, $urandom}, sz);
      else
        send_request($urandom_range(99) < 20 ? ACT_REMOVE : ACT_GET,
                     key_pool[$urandom_range(15)], sz);
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, hits, promotion, removes, oversize, full cache
    send_request(ACT_GET, '0, 24'd1);
    send_request(ACT_GET, '1, 24'hFFFFFF);
    send_request(ACT_GET, '0, 24'd1);
    send_request(ACT_REMOVE, '0, 24'd5);
    send_request(ACT_REMOVE, '0, 24'd5);
    send_request(ACT_GET, 64'h5555_AAAA_5555_AAAA, 24'd40000);
    send_request(ACT_GET, 64'hAAAA_5555_AAAA_5555, 24'd40000);
    for (int i = 0; i < 4; i++) send_request(ACT_GET, 64'(i + 16), 24'd8);
    send_request(ACT_GET, 64'hAAAA_5555_AAAA_5555, 24'd1);
    drain();
    write_reg(REG_DELAY, 32'd0);
    write_reg(REG_METADATA, 32'd16);
    write_reg(REG_CAPACITY, 32'd2000);
    for (int i = 0; i < 34; i++) send_request(ACT_GET, 64'(i + 100), 24'd10);
    send_request(ACT_GET, 64'd100 + 64'd33, 24'd10);
    send_request(ACT_GET, 64'd7, 24'd1990);
    drain();

    send_idle_pct = 15;
    recv_idle_pct = 75;
    write_reg(REG_DELAY, 32'd3);
    write_reg(REG_CAPACITY, 32'd20000);
    write_reg(REG_METADATA, 32'd0);
    random_phase(60);
    drain();

    send_idle_pct = 75;
    recv_idle_pct = 15;
    write_reg(REG_DELAY, 32'hFFFF_FFFF);
    write_reg(REG_CAPACITY, 32'hFFFF_FFFF);
    write_reg(REG_METADATA, 32'd16);
    random_phase(60);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_DELAY, 32'd1);
    write_reg(REG_CAPACITY, 32'd1);
    write_reg(REG_METADATA, 32'd0);
    send_request(ACT_GET, 64'd3, 24'd1);
    drain();
    write_reg(REG_CAPACITY, 32'd6000);
    random_phase(60);
    drain();

    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
